// File: rtl/cnfc_pkg.sv
package cnfc_pkg;

	localparam int unsigned MAX_VARS    = 65535;
	localparam int unsigned MAX_CLAUSES = 1048575;

	localparam int VAR_W = 16;
	localparam int CLS_W = 20;
	localparam int ACC_W = 21;
	localparam int LIT_W = 17;
	localparam int IDX_W = 16;
	localparam int ERR_W = 4;

	localparam int TAG_DEPTH = 2 ** IDX_W;

	localparam logic [ACC_W-1:0] ACC_CAP         = '1;
	localparam logic [ACC_W-1:0] MAX_VARS_ACC    = ACC_W'(MAX_VARS);
	localparam logic [ACC_W-1:0] MAX_CLAUSES_ACC = ACC_W'(MAX_CLAUSES);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE        = 4'd0,
		ERR_EOF         = 4'd1,
		ERR_BAD_CHAR    = 4'd2,
		ERR_BAD_HEADER  = 4'd3,
		ERR_ZERO_MISS   = 4'd4,
		ERR_CLAUSE_MISS = 4'd5,
		ERR_MINUS       = 4'd6,
		ERR_NO_DIGIT    = 4'd7,
		ERR_VAR_BIG     = 4'd8,
		ERR_CLAUSE_MANY = 4'd9,
		ERR_VAR_TWICE   = 4'd10
	} err_t;

	typedef enum logic [15:0] {
		MODE_START    = 16'h0001,
		MODE_HCOMMENT = 16'h0002,
		MODE_PRE_C    = 16'h0004,
		MODE_N        = 16'h0008,
		MODE_F        = 16'h0010,
		MODE_V_WS     = 16'h0020,
		MODE_V_SIGN   = 16'h0040,
		MODE_V_DIG    = 16'h0080,
		MODE_C_WS     = 16'h0100,
		MODE_C_SIGN   = 16'h0200,
		MODE_C_DIG    = 16'h0400,
		MODE_BODY     = 16'h0800,
		MODE_BCOMMENT = 16'h1000,
		MODE_MINUS    = 16'h2000,
		MODE_DIGIT    = 16'h4000,
		MODE_DONE     = 16'h8000
	} mode_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [CLS_W-1:0] wr_data;
	} tag_req_t;

	typedef struct packed {
		logic signed [LIT_W-1:0] literal;
		logic                    literal_valid;
		logic                    clause_end;
		logic [CLS_W-1:0]        clauses_read;
		logic                    header_valid;
		logic [VAR_W-1:0]        var_count;
		logic [CLS_W-1:0]        clause_total;
		logic [ERR_W-1:0]        error_code;
		logic                    finished;
	} result_t;

endpackage

// File: rtl/cnfc_tag_store.sv
module cnfc_tag_store
	import cnfc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  tag_req_t         req,
	output logic [CLS_W-1:0] rd_data,
	output logic             busy
);

	logic [CLS_W-1:0] mem [TAG_DEPTH];
	logic [CLS_W-1:0] rd_data_q;
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_idx_q;

	// clearing sweep after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_busy_q;

endmodule

// File: rtl/cnfc_parser.sv
module cnfc_parser
	import cnfc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       in_byte,
	input  logic             end_of_input,
	input  logic [CLS_W-1:0] tag_rd_data,
	output tag_req_t         tag_req,
	output result_t          result
);

	mode_t            mode_q;
	logic [VAR_W-1:0] hvars_q;
	logic [CLS_W-1:0] hcl_q;
	logic [CLS_W-1:0] closed_q;
	logic [ACC_W-1:0] acc_q;
	logic             neg_q;
	logic             lastnz_q;
	err_t             err_q;

	mode_t            mode_n;
	logic [VAR_W-1:0] hvars_n;
	logic [CLS_W-1:0] hcl_n;
	logic [CLS_W-1:0] closed_n;
	logic [ACC_W-1:0] acc_n;
	logic             neg_n;
	logic             lastnz_n;
	err_t             err_n;
	logic             active;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [CLS_W-1:0] wr_data;
	logic signed [LIT_W-1:0] lit;
	logic             lit_valid;
	logic             cl_end;

	always_comb begin
		logic             run;
		logic             eof;
		logic             dig;
		logic             hsp;
		logic             bsp;
		logic [ACC_W-1:0] dval;
		logic [ACC_W+3:0] prod;
		logic [CLS_W-1:0] tag;
		logic [LIT_W-1:0] mag;

		mode_n    = mode_q;
		hvars_n   = hvars_q;
		hcl_n     = hcl_q;
		closed_n  = closed_q;
		acc_n     = acc_q;
		neg_n     = neg_q;
		lastnz_n  = lastnz_q;
		err_n     = err_q;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = '0;
		lit       = '0;
		lit_valid = 1'b0;
		cl_end    = 1'b0;
		tag       = '0;
		mag       = '0;
		prod      = '0;

		eof  = end_of_input;
		dig  = !eof && (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
		hsp  = !eof && ((in_byte == CH_SP) || (in_byte == CH_TAB) || (in_byte == CH_LF) ||
			(in_byte == CH_VT) || (in_byte == CH_FF) || (in_byte == CH_CR));
		bsp  = !eof && ((in_byte == CH_SP) || (in_byte == CH_TAB) || (in_byte == CH_LF) ||
			(in_byte == CH_CR));
		dval = ACC_W'(in_byte[3:0]);

		active = (err_q == ERR_NONE) && (mode_q != MODE_DONE);
		run    = active;

		// a terminating byte is handled a second time in the follow-on mode
		for (int p = 0; p < 2; p++) begin
			if (run) begin
				run = 1'b0;
				case (mode_n)
					MODE_START: begin
						if (eof) err_n = ERR_EOF;
						else if (in_byte == CH_C) mode_n = MODE_HCOMMENT;
						else if (in_byte == CH_P) mode_n = MODE_PRE_C;
						else err_n = ERR_BAD_CHAR;
					end
					MODE_HCOMMENT: begin
						if (eof) err_n = ERR_EOF;
						else if (in_byte == CH_LF) mode_n = MODE_START;
					end
					MODE_PRE_C: begin
						if (!hsp) begin
							if (!eof && in_byte == CH_C) mode_n = MODE_N;
							else err_n = ERR_BAD_HEADER;
						end
					end
					MODE_N: begin
						if (!eof && in_byte == CH_N) mode_n = MODE_F;
						else err_n = ERR_BAD_HEADER;
					end
					MODE_F: begin
						if (!eof && in_byte == CH_F) mode_n = MODE_V_WS;
						else err_n = ERR_BAD_HEADER;
					end
					MODE_V_WS, MODE_C_WS: begin
						if (eof) begin
							err_n = ERR_BAD_HEADER;
						end else if (!hsp) begin
							if (in_byte == CH_PLUS || in_byte == CH_MINUS) begin
								neg_n  = (in_byte == CH_MINUS);
								mode_n = (mode_n == MODE_V_WS) ? MODE_V_SIGN : MODE_C_SIGN;
							end else if (dig) begin
								neg_n  = 1'b0;
								acc_n  = dval;
								mode_n = (mode_n == MODE_V_WS) ? MODE_V_DIG : MODE_C_DIG;
							end else begin
								err_n = ERR_BAD_HEADER;
							end
						end
					end
					MODE_V_SIGN, MODE_C_SIGN: begin
						if (dig) begin
							acc_n  = dval;
							mode_n = (mode_n == MODE_V_SIGN) ? MODE_V_DIG : MODE_C_DIG;
						end else begin
							err_n = ERR_BAD_HEADER;
						end
					end
					MODE_V_DIG, MODE_C_DIG, MODE_DIGIT: begin
						if (dig) begin
							prod = {1'b0, acc_n, 3'b000} + {3'b000, acc_n, 1'b0} + {4'b0000, dval};
							if (prod > {4'b0000, ACC_CAP}) acc_n = ACC_CAP;
							else acc_n = prod[ACC_W-1:0];
						end else if (mode_n == MODE_V_DIG) begin
							if ((neg_n && acc_n != '0) || acc_n > MAX_VARS_ACC) begin
								err_n = ERR_BAD_HEADER;
							end else begin
								hvars_n = acc_n[VAR_W-1:0];
								mode_n  = MODE_C_WS;
								run     = 1'b1;
							end
						end else if (mode_n == MODE_C_DIG) begin
							if ((neg_n && acc_n != '0) || acc_n > MAX_CLAUSES_ACC) begin
								err_n = ERR_BAD_HEADER;
							end else begin
								hcl_n  = acc_n[CLS_W-1:0];
								acc_n  = '0;
								neg_n  = 1'b0;
								mode_n = MODE_BODY;
								run    = 1'b1;
							end
						end else begin
							// literal complete
							tag = closed_n + CLS_W'(1);
							if (acc_n > {{(ACC_W-VAR_W){1'b0}}, hvars_n}) begin
								err_n = ERR_VAR_BIG;
							end else if (closed_n >= hcl_n) begin
								err_n = ERR_CLAUSE_MANY;
							end else if (acc_n != '0) begin
								if (tag_rd_data == tag) begin
									err_n = ERR_VAR_TWICE;
								end else begin
									wr_en     = 1'b1;
									wr_addr   = acc_n[IDX_W-1:0];
									wr_data   = tag;
									mag       = {1'b0, acc_n[VAR_W-1:0]};
									lit       = neg_n ? -$signed(mag) : $signed(mag);
									lit_valid = 1'b1;
									lastnz_n  = 1'b1;
								end
							end else begin
								closed_n = tag;
								cl_end   = 1'b1;
								lastnz_n = 1'b0;
							end
							if (err_n == ERR_NONE) begin
								acc_n  = '0;
								neg_n  = 1'b0;
								mode_n = MODE_BODY;
								run    = 1'b1;
							end
						end
					end
					MODE_BODY: begin
						if (eof) begin
							if (lastnz_n) err_n = ERR_ZERO_MISS;
							else if (closed_n < hcl_n) err_n = ERR_CLAUSE_MISS;
							else mode_n = MODE_DONE;
						end else if (bsp) begin
							mode_n = MODE_BODY;
						end else if (in_byte == CH_C) begin
							mode_n = MODE_BCOMMENT;
						end else if (in_byte == CH_MINUS) begin
							neg_n  = 1'b1;
							mode_n = MODE_MINUS;
						end else if (dig) begin
							neg_n  = 1'b0;
							acc_n  = dval;
							mode_n = MODE_DIGIT;
						end else begin
							err_n = ERR_NO_DIGIT;
						end
					end
					MODE_BCOMMENT: begin
						if (eof) err_n = ERR_EOF;
						else if (in_byte == CH_LF) mode_n = MODE_BODY;
					end
					MODE_MINUS: begin
						if (dig) begin
							acc_n  = dval;
							mode_n = MODE_DIGIT;
						end else begin
							err_n = ERR_MINUS;
						end
					end
					default: begin
						mode_n = mode_n;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_START;
			hvars_q  <= '0;
			hcl_q    <= '0;
			closed_q <= '0;
			acc_q    <= '0;
			neg_q    <= 1'b0;
			lastnz_q <= 1'b0;
			err_q    <= ERR_NONE;
		end else if (accept) begin
			mode_q   <= mode_n;
			hvars_q  <= hvars_n;
			hcl_q    <= hcl_n;
			closed_q <= closed_n;
			acc_q    <= acc_n;
			neg_q    <= neg_n;
			lastnz_q <= lastnz_n;
			err_q    <= err_n;
		end
	end

	// look up the tag of the number being built, ready for its terminator
	assign tag_req.rd_en   = accept && active && (mode_n == MODE_DIGIT);
	assign tag_req.rd_addr = acc_n[IDX_W-1:0];
	assign tag_req.wr_en   = accept && wr_en;
	assign tag_req.wr_addr = wr_addr;
	assign tag_req.wr_data = wr_data;

	logic hv_n;
	assign hv_n = (mode_n == MODE_BODY) || (mode_n == MODE_BCOMMENT) ||
		(mode_n == MODE_MINUS) || (mode_n == MODE_DIGIT) || (mode_n == MODE_DONE);

	assign result.literal       = lit;
	assign result.literal_valid = lit_valid;
	assign result.clause_end    = cl_end;
	assign result.clauses_read  = closed_n;
	assign result.header_valid  = hv_n;
	assign result.var_count     = hv_n ? hvars_n : '0;
	assign result.clause_total  = hv_n ? hcl_n : '0;
	assign result.error_code    = err_n;
	assign result.finished      = (mode_n == MODE_DONE) && (err_n == ERR_NONE);

endmodule

// File: rtl/cnf_text_tokenizer_checker.sv
// channel  | signals                                       | request
// ---------+-----------------------------------------------+-------------------------
// in       | in_valid, in_ready, in_byte, end_of_input     | one text byte or eof mark
// out      | out_valid, out_ready, literal .. finished     | one result per input
//
// one byte a cycle unless stalled by out_ready or the clearing pass; each result is
// registered on accept; the tag store read loop issued with each digit sets this rate
// after reset a clearing pass sweeps all 65536 tag store entries; in_ready is low
// a stalled result holds in the output register; the next byte is taken
// in the cycle that result leaves
module cnf_text_tokenizer_checker
	import cnfc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              in_byte,
	input  logic                    end_of_input,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [LIT_W-1:0] literal,
	output logic                    literal_valid,
	output logic                    clause_end,
	output logic [CLS_W-1:0]        clauses_read,
	output logic                    header_valid,
	output logic [VAR_W-1:0]        var_count,
	output logic [CLS_W-1:0]        clause_total,
	output logic [ERR_W-1:0]        error_code,
	output logic                    finished
);

	tag_req_t         tag_req;
	logic [CLS_W-1:0] tag_rd_data;
	logic             clr_busy;
	result_t          result;
	result_t          result_q;
	logic             out_valid_q;
	logic             accept;

	assign in_ready = !clr_busy && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	cnfc_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.tag_rd_data  (tag_rd_data),
		.tag_req      (tag_req),
		.result       (result)
	);

	cnfc_tag_store u_tags (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tag_req),
		.rd_data (tag_rd_data),
		.busy    (clr_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign literal       = result_q.literal;
	assign literal_valid = result_q.literal_valid;
	assign clause_end    = result_q.clause_end;
	assign clauses_read  = result_q.clauses_read;
	assign header_valid  = result_q.header_valid;
	assign var_count     = result_q.var_count;
	assign clause_total  = result_q.clause_total;
	assign error_code    = result_q.error_code;
	assign finished      = result_q.finished;

endmodule

// File: rtl/cnfc_checker.sv
module cnfc_checker
	import cnfc_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [LIT_W-1:0] literal,
	input logic                    literal_valid,
	input logic                    clause_end,
	input logic [CLS_W-1:0]        clauses_read,
	input logic                    header_valid,
	input logic [VAR_W-1:0]        var_count,
	input logic [CLS_W-1:0]        clause_total,
	input logic [ERR_W-1:0]        error_code,
	input logic                    finished
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(literal) &&
		$stable(error_code) && $stable(clauses_read) && $stable(literal_valid))
		else $error("result changed while stalled");

	a_lit_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && literal_valid |-> literal != 0 && !clause_end && header_valid)
		else $error("bad literal result");

	a_no_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !header_valid |-> var_count == 0 && clause_total == 0 &&
		clauses_read == 0 && !literal_valid && !clause_end)
		else $error("body output before header");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> error_code == ERR_NONE && header_valid &&
		clauses_read == clause_total && !literal_valid)
		else $error("finish with inconsistent state");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && error_code != ERR_NONE |=>
		!out_valid || error_code == $past(error_code))
		else $error("error code did not stick");

endmodule

bind cnf_text_tokenizer_checker cnfc_checker u_cnfc_checker (.*);
